FILE: rtl/core/dead_time_hit_merger_unit_macros.svh
// Assertion macros for the dead-time hit merger.
// Included by the port checker; no other dependencies.
`ifndef DEAD_TIME_HIT_MERGER_UNIT_MACROS_SVH
`define DEAD_TIME_HIT_MERGER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DTHM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define DTHM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/dthm_pkg.sv
// Shared widths, operation codes and cell interface structs
// for the dead-time hit merger. No dependencies.
package dthm_pkg;

	localparam int TIME_W    = 40;
	localparam int ENERGY_W  = 24;
	localparam int CHAN_W    = 4;
	localparam int UNIT_W    = 2;
	localparam int PD_W      = 2;
	localparam int DT_W      = 16;
	localparam int OP_W      = 2;
	localparam int CFG_IDX_W = 2;

	localparam int CHANNELS_DEF = 16;
	localparam int UNITS_DEF    = 4;

	localparam logic [DT_W-1:0] DT_RESET = 16'd100;

	localparam logic [OP_W-1:0] OP_HIT     = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_FLUSH   = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

	typedef struct packed {
		logic [TIME_W-1:0]   stamp;
		logic [ENERGY_W-1:0] energy;
		logic [CHAN_W-1:0]   channel;
		logic [UNIT_W-1:0]   unit;
		logic [PD_W-1:0]     pd;
		logic                last;
	} hit_out_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                is_hit;
		logic                hit_go;
		logic                mark_go;
		logic                flush;
		logic                grant;
		logic [CHAN_W-1:0]   channel;
		logic [TIME_W-1:0]   stamp;
		logic [ENERGY_W-1:0] energy;
		logic [UNIT_W-1:0]   unit;
		logic [PD_W-1:0]     pd;
		logic [DT_W-1:0]     dt_hit;
	} cell_cmd_t;

	typedef struct packed {
		logic     need_emit;
		logic     emit;
		hit_out_t data;
	} cell_rsp_t;

endpackage

FILE: rtl/core/dead_time_hit_merger_unit.sv
// A hit's displaced result is registered at the output after ST_EXEC, where an output
// stall can hold it. A new request is taken only in ST_IDLE; release and flush then scan in
// ST_SCAN, the token walking the cells one slot per cycle unless held by a stalled output.
// Reset clears all slots and sets every dead time to 100; no clearing pass is needed.
// Depends on dthm_pkg and dthm_cell.
module dead_time_hit_merger_unit #(
	parameter int CHANNELS = dthm_pkg::CHANNELS_DEF,
	parameter int UNITS    = dthm_pkg::UNITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [dthm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dthm_pkg::DT_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [dthm_pkg::OP_W-1:0]         operation,
	input  logic [dthm_pkg::CHAN_W-1:0]       channel,
	input  logic [dthm_pkg::UNIT_W-1:0]       unit,
	input  logic [dthm_pkg::PD_W-1:0]         photodetector,
	input  logic [dthm_pkg::TIME_W-1:0]       stamp,
	input  logic [dthm_pkg::ENERGY_W-1:0]     energy,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [dthm_pkg::TIME_W-1:0]       out_time,
	output logic [dthm_pkg::ENERGY_W-1:0]     out_energy,
	output logic [dthm_pkg::CHAN_W-1:0]       out_channel,
	output logic [dthm_pkg::UNIT_W-1:0]       out_unit,
	output logic [dthm_pkg::PD_W-1:0]         out_photodetector,
	output logic                              last
);

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SCAN} state_t;

	state_t                                state_q;
	logic [UNITS-1:0][dthm_pkg::DT_W-1:0]  dead_time_q;
	logic [dthm_pkg::OP_W-1:0]             op_q;
	logic [dthm_pkg::CHAN_W-1:0]           chan_q;
	logic [dthm_pkg::UNIT_W-1:0]           unit_q;
	logic [dthm_pkg::PD_W-1:0]             pd_q;
	logic [dthm_pkg::TIME_W-1:0]           stamp_q;
	logic [dthm_pkg::ENERGY_W-1:0]         energy_q;
	logic                                  out_valid_q;
	dthm_pkg::hit_out_t                    out_q;

	dthm_pkg::cell_cmd_t                   cmd;
	dthm_pkg::cell_rsp_t                   rsp [CHANNELS];
	logic [CHANNELS:0]                     token_link;
	logic [CHANNELS:0]                     mark_link;
	dthm_pkg::hit_out_t                    emit_data;
	logic                                  emit_any;
	logic                                  need_any;
	logic                                  out_free;
	logic                                  hit_ok;
	logic                                  scan_done;
	logic                                  in_take;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_take   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign hit_ok    = (int'(chan_q) < CHANNELS) && (int'(unit_q) < UNITS);
	assign scan_done = !mark_link[0] || token_link[CHANNELS];
	assign token_link[0]        = 1'b0;
	assign mark_link[CHANNELS]  = 1'b0;

	always_comb begin
		emit_any  = 1'b0;
		need_any  = 1'b0;
		emit_data = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			emit_any  = emit_any || rsp[i].emit;
			need_any  = need_any || rsp[i].need_emit;
			emit_data = emit_data | rsp[i].data;
		end
	end

	always_comb begin
		cmd.is_hit  = (op_q == dthm_pkg::OP_HIT);
		cmd.hit_go  = (state_q == ST_EXEC) && cmd.is_hit && hit_ok && (!need_any || out_free);
		cmd.mark_go = (state_q == ST_EXEC) &&
			((op_q == dthm_pkg::OP_RELEASE) || (op_q == dthm_pkg::OP_FLUSH));
		cmd.flush   = (op_q == dthm_pkg::OP_FLUSH);
		cmd.grant   = (state_q == ST_SCAN) && out_free;
		cmd.channel = chan_q;
		cmd.stamp   = stamp_q;
		cmd.energy  = energy_q;
		cmd.unit    = unit_q;
		cmd.pd      = pd_q;
		cmd.dt_hit  = '0;
		for (int u = 0; u < UNITS; u++) begin
			if (int'(unit_q) == u) begin
				cmd.dt_hit = dead_time_q[u];
			end
		end
	end

	for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
		dthm_cell #(
			.INDEX (i),
			.UNITS (UNITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.dead_time   (dead_time_q),
			.token_in    (token_link[i]),
			.token_out   (token_link[i+1]),
			.marks_above (mark_link[i+1]),
			.marks_here  (mark_link[i]),
			.rsp         (rsp[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_time_q <= {UNITS{dthm_pkg::DT_RESET}};
		end else begin
			for (int u = 0; u < UNITS; u++) begin
				if (cfg_write_en && (int'(cfg_index) == u)) begin
					dead_time_q[u] <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_any) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (op_q) inside
						dthm_pkg::OP_HIT: begin
							if (!hit_ok || cmd.hit_go) begin
								state_q <= ST_IDLE;
							end
						end
						dthm_pkg::OP_RELEASE, dthm_pkg::OP_FLUSH: begin
							state_q <= ST_SCAN;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q     <= operation;
			chan_q   <= channel;
			unit_q   <= unit;
			pd_q     <= photodetector;
			stamp_q  <= stamp;
			energy_q <= energy;
		end
		if (emit_any) begin
			out_q <= emit_data;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_time          = out_q.stamp;
	assign out_energy        = out_q.energy;
	assign out_channel       = out_q.channel;
	assign out_unit          = out_q.unit;
	assign out_photodetector = out_q.pd;
	assign last              = out_q.last;

endmodule

FILE: rtl/core/dthm_cell.sv
// One channel slot of the hit merger: held hit, merge logic, release mark
// and scan token. Depends on dthm_pkg.
module dthm_cell #(
	parameter int INDEX = 0,
	parameter int UNITS = dthm_pkg::UNITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  dthm_pkg::cell_cmd_t                      cmd,
	input  logic [UNITS-1:0][dthm_pkg::DT_W-1:0]     dead_time,
	input  logic                                     token_in,
	output logic                                     token_out,
	input  logic                                     marks_above,
	output logic                                     marks_here,
	output dthm_pkg::cell_rsp_t                      rsp
);

	localparam logic [dthm_pkg::CHAN_W-1:0] CHAN_ID = INDEX[dthm_pkg::CHAN_W-1:0];

	logic                          valid_q;
	logic                          mark_q;
	logic                          token_q;
	logic [dthm_pkg::TIME_W-1:0]   time_q;
	logic [dthm_pkg::ENERGY_W-1:0] energy_q;
	logic [dthm_pkg::UNIT_W-1:0]   unit_q;
	logic [dthm_pkg::PD_W-1:0]     pd_q;

	logic                          sel;
	logic [dthm_pkg::DT_W-1:0]     dt_slot;
	logic [dthm_pkg::DT_W-1:0]     dt_use;
	logic [dthm_pkg::TIME_W:0]     diff_fwd;
	logic [dthm_pkg::TIME_W-1:0]   diff_rev;
	logic [dthm_pkg::TIME_W-1:0]   distance;
	logic                          stamp_below;
	logic                          dist_small;
	logic                          in_window;
	logic                          reach;
	logic [dthm_pkg::ENERGY_W:0]   esum;
	logic [dthm_pkg::ENERGY_W-1:0] esat;
	logic                          hit_emit;
	logic                          scan_emit;
	logic                          emit;

	always_comb begin
		sel = cmd.is_hit && (int'(cmd.channel) == INDEX);
		dt_slot = '0;
		for (int u = 0; u < UNITS; u++) begin
			if (int'(unit_q) == u) begin
				dt_slot = dead_time[u];
			end
		end
		dt_use      = cmd.is_hit ? cmd.dt_hit : dt_slot;
		diff_fwd    = {1'b0, cmd.stamp} - {1'b0, time_q};
		diff_rev    = time_q - cmd.stamp;
		stamp_below = diff_fwd[dthm_pkg::TIME_W];
		distance    = stamp_below ? diff_rev : diff_fwd[dthm_pkg::TIME_W-1:0];
		dist_small  = (distance[dthm_pkg::TIME_W-1:dthm_pkg::DT_W] == '0);
		in_window   = dist_small && (distance[dthm_pkg::DT_W-1:0] < dt_use);
		reach       = dist_small && (distance[dthm_pkg::DT_W-1:0] <= dt_use);
		esum        = {1'b0, energy_q} + {1'b0, cmd.energy};
		esat        = esum[dthm_pkg::ENERGY_W] ? '1 : esum[dthm_pkg::ENERGY_W-1:0];

		hit_emit  = sel && valid_q && !in_window;
		scan_emit = token_q && mark_q && cmd.grant;
		emit      = (cmd.hit_go && hit_emit) || scan_emit;

		token_out  = token_q && (!mark_q || cmd.grant);
		marks_here = mark_q || marks_above;

		rsp.need_emit    = hit_emit;
		rsp.emit         = emit;
		rsp.data.stamp   = emit ? time_q : '0;
		rsp.data.energy  = emit ? energy_q : '0;
		rsp.data.channel = emit ? CHAN_ID : '0;
		rsp.data.unit    = emit ? unit_q : '0;
		rsp.data.pd      = emit ? pd_q : '0;
		rsp.data.last    = emit && (!scan_emit || !marks_above);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			mark_q  <= 1'b0;
			token_q <= 1'b0;
		end else begin
			if (cmd.mark_go) begin
				mark_q  <= valid_q && (cmd.flush || !reach);
				token_q <= (INDEX == 0);
			end else begin
				token_q <= token_in || (token_q && !token_out);
				if (scan_emit) begin
					mark_q  <= 1'b0;
					valid_q <= 1'b0;
				end
			end
			if (cmd.hit_go && sel) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hit_go && sel) begin
			if (valid_q && in_window) begin
				energy_q <= esat;
				if (stamp_below) begin
					time_q <= cmd.stamp;
				end
			end else begin
				time_q   <= cmd.stamp;
				energy_q <= cmd.energy;
				unit_q   <= cmd.unit;
				pd_q     <= cmd.pd;
			end
		end
	end

endmodule

FILE: rtl/core/dthm_checker.sv
// Port-level checker for the dead-time hit merger, bound to the top level.
// Depends on dthm_pkg and dead_time_hit_merger_unit_macros.svh.
`include "dead_time_hit_merger_unit_macros.svh"

module dthm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [dthm_pkg::OP_W-1:0]         operation,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [dthm_pkg::TIME_W-1:0]       out_time,
	input logic [dthm_pkg::ENERGY_W-1:0]     out_energy,
	input logic [dthm_pkg::CHAN_W-1:0]       out_channel,
	input logic [dthm_pkg::UNIT_W-1:0]       out_unit,
	input logic [dthm_pkg::PD_W-1:0]         out_photodetector,
	input logic                              last
);

	// one request in flight: no new request right after one is taken
	`DTHM_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready, "request taken while busy")

	// results only come out of request processing
	`DTHM_ASSERT_NOW(a_result_while_busy, clk, arst_n, $rose(out_valid), !$past(in_ready), "result appeared while idle")

	// stalled result holds
	`DTHM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_time) && $stable(out_energy) && $stable(out_channel) && $stable(out_unit) && $stable(out_photodetector) && $stable(last), "stalled result changed")

	// unknown operation is dropped: the unit is ready again after its execute state
	`DTHM_ASSERT_NEXT(a_unknown_op, clk, arst_n, in_valid && in_ready && (operation == dthm_pkg::OP_NONE), ##1 in_ready, "unknown operation not dropped")

endmodule

bind dead_time_hit_merger_unit dthm_checker u_dthm_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_ready          (in_ready),
	.operation         (operation),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.out_time          (out_time),
	.out_energy        (out_energy),
	.out_channel       (out_channel),
	.out_unit          (out_unit),
	.out_photodetector (out_photodetector),
	.last              (last)
);
